>>> rtl/lrbc_pkg.sv
// ----------------------------------------------------------------------------
// lrbc_pkg
// Shared types and constants for the range block cache.
// ----------------------------------------------------------------------------
package lrbc_pkg;

    localparam int OFFSET_W = 48;
    localparam int SIZE_W   = 32;
    localparam int HANDLE_W = 16;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic                command;
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   entry_size;
        logic [HANDLE_W-1:0] entry_handle;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [OFFSET_W-1:0] hit_start;
        logic [SIZE_W-1:0]   hit_size;
        logic [HANDLE_W-1:0] hit_handle;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
    } rsp_t;

    typedef struct packed {
        logic                valid;
        logic [OFFSET_W-1:0] start;
        logic [SIZE_W-1:0]   length;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic                capture;
        logic                update;
        logic                lookup;
        logic                any_hit;
        logic [OFFSET_W-1:0] offset;
    } ctrl_t;

endpackage

>>> rtl/lru_range_block_cache_top.sv
// ----------------------------------------------------------------------------
// lru_range_block_cache_top
// Fully associative cache of decoded blocks kept in most-recently-used order.
// ----------------------------------------------------------------------------
// A request is accepted in ST_IDLE. In the cycle a request is accepted,
// each cell compares the offset against its own range in parallel and
// registers the result. In ST_UPDATE, once no previous response is pending
// or it is being taken, the row of cells shifts by one slot up to the first
// covering entry (lookup) or along the whole row (insert), slot 0 is loaded,
// and the response goes to the output register; a lookup miss shifts nothing.
// s_ready is low in ST_UPDATE, so a new request waits for the last update.
module lru_range_block_cache_top #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lrbc_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output lrbc_pkg::rsp_t m_data
);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    lrbc_pkg::req_t   req_reg;
    lrbc_pkg::req_t   req_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    lrbc_pkg::rsp_t   rsp_reg;
    lrbc_pkg::rsp_t   rsp_next;

    lrbc_pkg::ctrl_t  ctrl;
    lrbc_pkg::entry_t cell_entry [CACHE_ENTRIES];
    logic             cell_match [CACHE_ENTRIES];
    logic             found [CACHE_ENTRIES+1];
    lrbc_pkg::entry_t head_entry;
    lrbc_pkg::entry_t hit_sel;
    logic             accept;
    logic             do_update;
    lrbc_pkg::entry_t last_entry;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign do_update = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);
    assign found[0]  = 1'b0;
    assign last_entry = cell_entry[CACHE_ENTRIES-1];

    always_comb begin
        ctrl.capture = accept;
        ctrl.update  = do_update;
        ctrl.lookup  = (req_reg.command == lrbc_pkg::CMD_LOOKUP);
        ctrl.any_hit = found[CACHE_ENTRIES];
        ctrl.offset  = s_data.offset;
    end

    // first covering entry, one-hot and-or select
    always_comb begin
        hit_sel = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (cell_match[i] && !found[i]) begin
                hit_sel = hit_sel | cell_entry[i];
            end
        end
    end

    always_comb begin
        if (req_reg.command == lrbc_pkg::CMD_INSERT) begin
            head_entry.valid  = 1'b1;
            head_entry.start  = req_reg.offset;
            head_entry.length = req_reg.entry_size;
            head_entry.handle = req_reg.entry_handle;
        end else begin
            head_entry       = hit_sel;
            head_entry.valid = 1'b1;
        end
    end

    generate
        for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
            lrbc_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .prev_entry ((g == 0) ? head_entry : cell_entry[(g == 0) ? 0 : g-1]),
                .found_in   (found[g]),
                .entry      (cell_entry[g]),
                .match      (cell_match[g]),
                .found_out  (found[g+1])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        m_valid_next = m_valid_reg;
        rsp_next     = rsp_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next   = s_data;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (do_update) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (req_reg.command == lrbc_pkg::CMD_INSERT) begin
                        rsp_next.hit            = 1'b1;
                        rsp_next.hit_start      = req_reg.offset;
                        rsp_next.hit_size       = req_reg.entry_size;
                        rsp_next.hit_handle     = req_reg.entry_handle;
                        rsp_next.evicted        = last_entry.valid;
                        rsp_next.evicted_handle = last_entry.valid ? last_entry.handle : '0;
                    end else begin
                        rsp_next.hit            = found[CACHE_ENTRIES];
                        rsp_next.hit_start      = hit_sel.start;
                        rsp_next.hit_size       = hit_sel.length;
                        rsp_next.hit_handle     = hit_sel.handle;
                        rsp_next.evicted        = 1'b0;
                        rsp_next.evicted_handle = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

>>> rtl/lrbc_cell.sv
// ----------------------------------------------------------------------------
// lrbc_cell
// One cache slot: holds an entry, compares its range against a request
// offset and shifts in its neighbor's entry when the order changes.
// ----------------------------------------------------------------------------
module lrbc_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  lrbc_pkg::ctrl_t  ctrl,
    input  lrbc_pkg::entry_t prev_entry,
    input  logic             found_in,
    output lrbc_pkg::entry_t entry,
    output logic             match,
    output logic             found_out
);

    lrbc_pkg::entry_t                entry_reg;
    lrbc_pkg::entry_t                entry_next;
    logic                            match_reg;
    logic                            match_next;
    logic [lrbc_pkg::OFFSET_W-1:0]   diff;
    logic                            covers;
    logic                            shift;

    always_comb begin
        diff   = ctrl.offset - entry_reg.start;
        covers = entry_reg.valid && (entry_reg.start <= ctrl.offset) &&
                 (diff < {{(lrbc_pkg::OFFSET_W-lrbc_pkg::SIZE_W){1'b0}}, entry_reg.length});
        match_next = ctrl.capture ? covers : match_reg;
        shift = ctrl.update && (ctrl.lookup ? (ctrl.any_hit && !found_in) : 1'b1);
        entry_next = shift ? prev_entry : entry_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
            match_reg       <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
            match_reg       <= match_next;
        end
        entry_reg.start  <= entry_next.start;
        entry_reg.length <= entry_next.length;
        entry_reg.handle <= entry_next.handle;
    end

    assign entry     = entry_reg;
    assign match     = match_reg;
    assign found_out = found_in | match_reg;

endmodule
